[rtl/pf_pkg.sv]
package pf_pkg;

    localparam int LTR_W       = 5;
    localparam int CELL_W      = 5;
    localparam int NUM_LETTERS = 26;
    localparam int GRID_CELLS  = 25;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;

    localparam logic [LTR_W-1:0] LTR_I    = 5'd8;
    localparam logic [LTR_W-1:0] LTR_J    = 5'd9;
    localparam logic [LTR_W-1:0] LTR_Q    = 5'd16;
    localparam logic [LTR_W-1:0] LTR_X    = 5'd23;
    localparam logic [LTR_W-1:0] LTR_Z    = 5'd25;
    localparam logic [LTR_W-1:0] LTR_LAST = 5'd25;

    localparam logic [6:0] ASCII_UPPER_A = 7'd65;
    localparam logic [7:0] ASCII_A_UC    = 8'd65;
    localparam logic [7:0] ASCII_Z_UC    = 8'd90;
    localparam logic [7:0] ASCII_A_LC    = 8'd97;
    localparam logic [7:0] ASCII_Z_LC    = 8'd122;

    typedef logic [LTR_W-1:0]  t_letter;
    typedef logic [CELL_W-1:0] t_cell;

    typedef struct packed {
        logic    ok;
        t_letter idx;
    } t_ltr;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } t_rc;

    // Upper-case, map to 0..25 and fold J onto I.
    function automatic t_ltr letter_of(input logic [7:0] b);
        t_ltr       res;
        logic [7:0] d;
        res = '0;
        d   = '0;
        if (b >= ASCII_A_LC && b <= ASCII_Z_LC) begin
            d      = b - ASCII_A_LC;
            res.ok = 1'b1;
        end else if (b >= ASCII_A_UC && b <= ASCII_Z_UC) begin
            d      = b - ASCII_A_UC;
            res.ok = 1'b1;
        end
        res.idx = d[LTR_W-1:0];
        if (res.idx == LTR_J) begin
            res.idx = LTR_I;
        end
        return res;
    endfunction

    function automatic t_letter fill_of(input t_letter l);
        return (l == LTR_X) ? LTR_Q : LTR_X;
    endfunction

    function automatic t_letter pad_of(input t_letter l);
        return (l == LTR_Z) ? LTR_X : LTR_Z;
    endfunction

    function automatic t_rc cell_rc(input t_cell c);
        t_rc   res;
        t_cell base;
        if (c >= 5'd20) begin
            res.row = 3'd4;
            base    = 5'd20;
        end else if (c >= 5'd15) begin
            res.row = 3'd3;
            base    = 5'd15;
        end else if (c >= 5'd10) begin
            res.row = 3'd2;
            base    = 5'd10;
        end else if (c >= 5'd5) begin
            res.row = 3'd1;
            base    = 5'd5;
        end else begin
            res.row = 3'd0;
            base    = 5'd0;
        end
        res.col = 3'(c - base);
        return res;
    endfunction

    function automatic t_cell rc_cell(input logic [2:0] r, input logic [2:0] k);
        t_cell r5;
        r5 = {2'b00, r};
        return (r5 << 2) + r5 + {2'b00, k};
    endfunction

    // One step along a row or column, wrapping around the grid edge.
    function automatic logic [2:0] step5(input logic [2:0] x, input logic back);
        logic [2:0] res;
        if (back) begin
            res = (x == 3'd0) ? 3'd4 : x - 3'd1;
        end else begin
            res = (x == 3'd4) ? 3'd0 : x + 3'd1;
        end
        return res;
    endfunction

endpackage

[rtl/pf_ram.sv]
module pf_ram
    import pf_pkg::*;
#(
    parameter int P_WIDTH = LTR_W,
    parameter int P_DEPTH = NUM_LETTERS
) (
    input  logic                                           i_clk,
    input  logic                                           i_we,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]                             i_wdata,
    input  logic                                           i_re,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]                             o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Hold read data until the next read.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/playfair_digraph_cipher_core.sv]
// Key byte: taken in S_IDLE. Finish: an S_FILL walk over all 26 letters, one letter a cycle.
// Text pair: states S_RDA, S_RDB and S_CALC, then the letters are set in S_EM1 and S_EM2,
// each when the output is free; up to 2 pairs per item, the steps set by the single read port of
// each table (two letter-to-cell reads, then two cell-to-letter reads per pair).
// Reset (synchronous, active low) clears the grid state, the held letter and the mode;
// table contents are undefined until the key is finished; then all but J's entry are written.
module playfair_digraph_cipher_core
    import pf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_char_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_cipher_letter,
    output logic       o_last_of_run,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_CALC = 3'd4;
    localparam logic [2:0] S_EM1  = 3'd5;
    localparam logic [2:0] S_EM2  = 3'd6;

    // control
    logic [2:0]            r_state, n_state;
    logic [NUM_LETTERS-1:0] r_letters_used, n_letters_used;
    logic [CELL_W-1:0]     r_cells_filled, n_cells_filled;
    logic                  r_grid_ready, n_grid_ready;
    logic                  r_held_valid, n_held_valid;
    logic                  r_decrypt_mode, n_decrypt_mode;
    logic                  r_more, n_more;
    logic                  r_out_valid, n_out_valid;
    t_letter               r_k, n_k;

    // payload
    t_letter r_held_letter, n_held_letter;
    t_letter r_pa, n_pa, r_pb, n_pb, r_qa, n_qa, r_qb, n_qb;
    t_cell   r_ca, n_ca, r_o2, n_o2;
    logic [6:0] r_out_letter, n_out_letter;
    logic       r_out_last, n_out_last;

    // memory ports
    logic    wr_en;
    t_letter wr_letter;
    logic    l2c_re, c2l_re;
    t_letter l2c_raddr;
    t_cell   c2l_raddr;
    t_cell   l2c_rdata;
    t_letter c2l_rdata;

    logic    in_acc, out_free;
    t_ltr    in_ltr;
    logic    p1, p2, hv1;
    t_letter h1, p1b;
    t_rc     rc_a, rc_b;
    logic [2:0] ra, ka, rb, kb;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cipher_letter = r_out_letter;
    assign o_last_of_run   = r_out_last;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign in_ltr   = letter_of(i_char_byte);

    always_comb begin
        n_state        = r_state;
        n_letters_used = r_letters_used;
        n_cells_filled = r_cells_filled;
        n_grid_ready   = r_grid_ready;
        n_held_valid   = r_held_valid;
        n_held_letter  = r_held_letter;
        n_decrypt_mode = i_cfg_we ? i_cfg_wdata : r_decrypt_mode;
        n_more         = r_more;
        n_k            = r_k;
        n_pa           = r_pa;
        n_pb           = r_pb;
        n_qa           = r_qa;
        n_qb           = r_qb;
        n_ca           = r_ca;
        n_o2           = r_o2;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_letter   = r_out_letter;
        n_out_last     = r_out_last;

        wr_en     = 1'b0;
        wr_letter = in_ltr.idx;
        l2c_re    = 1'b0;
        l2c_raddr = r_pb;
        c2l_re    = 1'b0;
        c2l_raddr = r_o2;

        // pairing decisions for a text letter
        p1  = in_ltr.ok && r_held_valid;
        p1b = (in_ltr.idx != r_held_letter) ? in_ltr.idx : fill_of(r_held_letter);
        if (in_ltr.ok) begin
            h1  = in_ltr.idx;
            hv1 = !(r_held_valid && (in_ltr.idx != r_held_letter));
        end else begin
            h1  = r_held_letter;
            hv1 = r_held_valid;
        end
        p2 = i_end_of_text && hv1;

        rc_a = cell_rc(r_ca);
        rc_b = cell_rc(l2c_rdata);
        ra = rc_a.row;
        ka = rc_a.col;
        rb = rc_b.row;
        kb = rc_b.col;
        if (rc_a.row == rc_b.row) begin
            ka = step5(rc_a.col, r_decrypt_mode);
            kb = step5(rc_b.col, r_decrypt_mode);
        end else if (rc_a.col == rc_b.col) begin
            ra = step5(rc_a.row, r_decrypt_mode);
            rb = step5(rc_b.row, r_decrypt_mode);
        end else begin
            ka = rc_b.col;
            kb = rc_a.col;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_operation)
                        OP_KEY: begin
                            if (!r_grid_ready && in_ltr.ok &&
                                !r_letters_used[in_ltr.idx] &&
                                (r_cells_filled < CELL_W'(GRID_CELLS))) begin
                                wr_en = 1'b1;
                            end
                        end
                        OP_FINISH: begin
                            if (!r_grid_ready) begin
                                n_k     = '0;
                                n_state = S_FILL;
                            end
                        end
                        OP_TEXT: begin
                            if (r_grid_ready) begin
                                n_held_letter = h1;
                                n_held_valid  = hv1 && !p2;
                                n_more        = p1 && p2;
                                n_qa          = h1;
                                n_qb          = pad_of(h1);
                                if (p1) begin
                                    n_pa = r_held_letter;
                                    n_pb = p1b;
                                end else begin
                                    n_pa = h1;
                                    n_pb = pad_of(h1);
                                end
                                if (p1 || p2) begin
                                    n_state = S_RDA;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                wr_letter = r_k;
                if ((r_k != LTR_J) && !r_letters_used[r_k] &&
                    (r_cells_filled < CELL_W'(GRID_CELLS))) begin
                    wr_en = 1'b1;
                end
                if (r_k == LTR_LAST) begin
                    n_grid_ready = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_RDA: begin
                l2c_re    = 1'b1;
                l2c_raddr = r_pa;
                n_state   = S_RDB;
            end
            S_RDB: begin
                n_ca      = l2c_rdata;
                l2c_re    = 1'b1;
                l2c_raddr = r_pb;
                n_state   = S_CALC;
            end
            S_CALC: begin
                c2l_re    = 1'b1;
                c2l_raddr = rc_cell(ra, ka);
                n_o2      = rc_cell(rb, kb);
                n_state   = S_EM1;
            end
            S_EM1: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_letter = ASCII_UPPER_A + {2'b00, c2l_rdata};
                    n_out_last   = 1'b0;
                    c2l_re       = 1'b1;
                    c2l_raddr    = r_o2;
                    n_state      = S_EM2;
                end
            end
            S_EM2: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_letter = ASCII_UPPER_A + {2'b00, c2l_rdata};
                    n_out_last   = !r_more;
                    if (r_more) begin
                        n_pa    = r_qa;
                        n_pb    = r_qb;
                        n_more  = 1'b0;
                        n_state = S_RDA;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (wr_en) begin
            n_letters_used[wr_letter] = 1'b1;
            n_cells_filled            = r_cells_filled + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_letters_used <= '0;
            r_cells_filled <= '0;
            r_grid_ready   <= 1'b0;
            r_held_valid   <= 1'b0;
            r_decrypt_mode <= 1'b0;
            r_more         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_k            <= '0;
            r_held_letter  <= '0;
        end else begin
            r_state        <= n_state;
            r_letters_used <= n_letters_used;
            r_cells_filled <= n_cells_filled;
            r_grid_ready   <= n_grid_ready;
            r_held_valid   <= n_held_valid;
            r_decrypt_mode <= n_decrypt_mode;
            r_more         <= n_more;
            r_out_valid    <= n_out_valid;
            r_k            <= n_k;
            r_held_letter  <= n_held_letter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa         <= n_pa;
        r_pb         <= n_pb;
        r_qa         <= n_qa;
        r_qb         <= n_qb;
        r_ca         <= n_ca;
        r_o2         <= n_o2;
        r_out_letter <= n_out_letter;
        r_out_last   <= n_out_last;
    end

    pf_ram #(
        .P_WIDTH (CELL_W),
        .P_DEPTH (NUM_LETTERS)
    ) u_letter_to_cell (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_letter),
        .i_wdata (r_cells_filled),
        .i_re    (l2c_re),
        .i_raddr (l2c_raddr),
        .o_rdata (l2c_rdata)
    );

    pf_ram #(
        .P_WIDTH (LTR_W),
        .P_DEPTH (GRID_CELLS)
    ) u_cell_to_letter (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_cells_filled),
        .i_wdata (wr_letter),
        .i_re    (c2l_re),
        .i_raddr (c2l_raddr),
        .o_rdata (c2l_rdata)
    );

`ifndef ASSERT_OFF
    a_used_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_letters_used) == int'(r_cells_filled))
        else $error("letters_used count differs from cells_filled");

    a_no_j_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_letters_used[LTR_J])
        else $error("J placed in grid");

    a_fill_before_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !r_grid_ready)
        else $error("alphabet walk after grid finished");

    a_text_needs_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDA) |-> r_grid_ready)
        else $error("pair lookup before grid finished");

    a_full_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_grid_ready) |-> (r_cells_filled == CELL_W'(GRID_CELLS)))
        else $error("grid finished with empty cells");
`endif

endmodule
